@@ design/wri_pkg.sv @@
`timescale 1ns / 1ps
package wri_pkg;
  // Defaults for the top level parameters
  localparam int DEF_MAX_PERIOD    = 64;
  localparam int DEF_PRICE_BITS    = 32;
  localparam int DEF_AVG_FRAC_BITS = 16;

  // Period register
  localparam int             PERIOD_W     = 7;
  localparam logic [6:0]     PERIOD_RESET = 7'd14;
  localparam int             MIN_PERIOD   = 2;

  // RSI in hundredths of a percent
  localparam int             RSI_W    = 14;
  localparam logic [13:0]    RSI_FULL = 14'd10000;

  // Entries of the input queue
  localparam int Q_DEPTH = 2;
endpackage

@@ design/wri_if.sv @@
`timescale 1ns / 1ps
interface wri_in_if #(parameter int PRICE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  new_bar;

  modport source (output valid, output price, output new_bar, input ready);
  modport sink   (input valid, input price, input new_bar, output ready);
endinterface

interface wri_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] rsi_final;
  logic [13:0] rsi_live;
  logic        final_valid;
  logic        live_valid;

  modport source (output valid, output rsi_final, output rsi_live,
                  output final_valid, output live_valid, input ready);
  modport sink   (input valid, input rsi_final, input rsi_live,
                  input final_valid, input live_valid, output ready);
endinterface

@@ design/wri_front.sv @@
`timescale 1ns / 1ps
module wri_front #(
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic                  in_new_bar,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [PRICE_BITS-1:0] q_price,
  output logic                  q_new_bar
);
  import wri_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int LVL_W = $clog2(Q_DEPTH + 1);

  logic [PRICE_BITS-1:0] price_q [Q_DEPTH];
  logic                  nb_q    [Q_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0]      level_r, level_nxt;
  logic                  push, pop;

  assign in_ready  = (level_r != LVL_W'(Q_DEPTH));
  assign q_valid   = (level_r != '0);
  assign q_price   = price_q[rd_ptr_r];
  assign q_new_bar = nb_q[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = q_valid && q_ready;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Store the incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      price_q[wr_ptr_r] <= in_price;
      nb_q[wr_ptr_r]    <= in_new_bar;
    end
  end
endmodule

@@ design/wri_div.sv @@
`timescale 1ns / 1ps
module wri_div #(
  parameter int DDW = 64,
  parameter int DSW = 49
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DDW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DDW-1:0] quotient
);
  localparam int CNT_W = $clog2(DDW + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DSW-1:0]   rem_r, rem_nxt;
  logic [DDW-1:0]   q_r, q_nxt;
  logic [DSW-1:0]   dsr_r;
  logic             done_r;
  logic [DSW:0]     trial;

  assign done     = done_r;
  assign quotient = q_r;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, q_r[DDW-1]};
    rem_nxt = trial[DSW-1:0];
    q_nxt   = {q_r[DDW-2:0], 1'b0};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt  = DSW'(trial - {1'b0, dsr_r});
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DDW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end
endmodule

@@ design/wri_core.sv @@
`timescale 1ns / 1ps
module wri_core #(
  parameter int MAX_PERIOD    = 64,
  parameter int PRICE_BITS    = 32,
  parameter int AVG_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wri_pkg::PERIOD_W-1:0]  cfg_wdata,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [PRICE_BITS-1:0]         q_price,
  input  logic                          q_new_bar,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wri_pkg::RSI_W-1:0]     out_rsi_final,
  output logic [wri_pkg::RSI_W-1:0]     out_rsi_live,
  output logic                          out_final_valid,
  output logic                          out_live_valid
);
  import wri_pkg::*;

  localparam int P     = PRICE_BITS;
  localparam int F     = AVG_FRAC_BITS;
  localparam int PW    = $clog2(MAX_PERIOD + 1);
  localparam int AD    = $clog2(MAX_PERIOD);
  localparam int AW    = P + F;
  localparam int SW    = P + PW;
  localparam int NW    = AW + PW + 1;
  localparam int RNW   = AW + RSI_W + 1;
  localparam int DDW   = (NW > RNW) ? NW : RNW;
  localparam int DSW   = AW + 1;
  localparam int CW    = (PW > PERIOD_W) ? PW : PERIOD_W;
  localparam int XW    = PW + 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WALK = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DIVU = 4'd3;
  localparam logic [3:0] S_DIVD = 4'd4;
  localparam logic [3:0] S_RMUL = 4'd5;
  localparam logic [3:0] S_DIVR = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // Kinds of tick
  localparam logic [2:0] M_OPEN   = 3'd0;
  localparam logic [2:0] M_HOLD   = 3'd1;
  localparam logic [2:0] M_PUSH   = 3'd2;
  localparam logic [2:0] M_SEED   = 3'd3;
  localparam logic [2:0] M_SMOOTH = 3'd4;
  localparam logic [2:0] M_LIVE   = 3'd5;

  logic [3:0]          state_r;
  logic [2:0]          mode_r;
  logic [PERIOD_W-1:0] period_r;
  logic [PW-1:0]       p_eff, p_r;
  logic [CW-1:0]       per_ext;
  logic [P-1:0]        price_r;
  logic                bar_open_r, smooth_on_r;
  logic [PW-1:0]       cnt_r;
  logic [AD-1:0]       wp_r;
  logic [P-1:0]        bar_close_r, last_close_r;
  logic [AW-1:0]       avg_up_r, avg_dn_r;
  logic [AW-1:0]       t_up_r, t_dn_r;
  logic [RSI_W-1:0]    rsi_final_r, rsi_live_r, rsi_r;
  logic [NW-1:0]       num_up_r, num_dn_r;
  logic [RNW-1:0]      rnum_r;
  logic [DSW-1:0]      rden_r;
  logic                div_go_r;
  logic                rn_ok_r;

  // Window walk
  logic [PW-1:0]       k_r;
  logic                issuing_r, pend_r, first_r;
  logic [P-1:0]        prev_r;
  logic [SW-1:0]       su_r, sd_r;
  logic [XW-1:0]       addr_x;
  logic [AD-1:0]       rd_addr;
  logic [P-1:0]        rd_data_r;
  logic [P-1:0]        hist_mem [MAX_PERIOD];
  logic                mem_we;

  // Arithmetic
  logic [P-1:0]        mv_src, mu, md;
  logic [AW+PW-1:0]    prod_up, prod_dn;
  logic [PW-1:0]       pm1;
  logic [AW+RSI_W-1:0] prod_r;
  logic [DSW-1:0]      sum_t;

  // Divider hookup
  logic                div_start, div_done;
  logic [DDW-1:0]      div_dividend, div_q;
  logic [DSW-1:0]      div_divisor;

  // Clamp the period to its working range
  always_comb begin
    per_ext = CW'(period_r);
    if (per_ext < CW'(MIN_PERIOD)) begin
      p_eff = PW'(MIN_PERIOD);
    end else if (per_ext > CW'(MAX_PERIOD)) begin
      p_eff = PW'(MAX_PERIOD);
    end else begin
      p_eff = PW'(per_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  // History slot k back from newest sits at wp - 1 - k, wrapped
  always_comb begin
    addr_x = XW'(wp_r) + XW'(MAX_PERIOD - 1) - XW'(k_r);
    if (addr_x >= XW'(MAX_PERIOD)) begin
      addr_x = addr_x - XW'(MAX_PERIOD);
    end
    rd_addr = AD'(addr_x);
  end

  assign mem_we = (state_r == S_FIN) &&
                  (mode_r == M_PUSH || mode_r == M_SEED || mode_r == M_SMOOTH);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wp_r] <= bar_close_r;
    end
    rd_data_r <= hist_mem[rd_addr];
  end

  // Move of the closing or trial price against the last closed bar
  always_comb begin
    mv_src  = (mode_r == M_LIVE) ? price_r : bar_close_r;
    mu      = (mv_src >= last_close_r) ? mv_src - last_close_r : '0;
    md      = (mv_src <  last_close_r) ? last_close_r - mv_src : '0;
    pm1     = p_r - 1'b1;
    prod_up = avg_up_r * pm1;
    prod_dn = avg_dn_r * pm1;
    sum_t   = DSW'(t_up_r) + DSW'(t_dn_r);
  end

  // Feed the shared divider
  always_comb begin
    div_start    = (state_r == S_DIVU || state_r == S_DIVD || state_r == S_DIVR) &&
                   !div_go_r;
    div_dividend = DDW'(num_up_r);
    div_divisor  = DSW'(p_r);
    if (state_r == S_DIVD) begin
      div_dividend = DDW'(num_dn_r);
    end else if (state_r == S_DIVR) begin
      div_dividend = DDW'(rnum_r);
      div_divisor  = rden_r;
    end
  end

  wri_div #(.DDW(DDW), .DSW(DSW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_ready = (state_r == S_IDLE);

  // Control sequence for one tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bar_open_r  <= 1'b0;
      smooth_on_r <= 1'b0;
      cnt_r       <= '0;
      wp_r        <= '0;
      rsi_final_r <= '0;
      rsi_live_r  <= '0;
      out_valid   <= 1'b0;
      div_go_r    <= 1'b0;
      issuing_r   <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (out_valid && out_ready && state_r != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            price_r <= q_price;
            p_r     <= p_eff;
            if (!bar_open_r) begin
              mode_r  <= M_OPEN;
              state_r <= S_FIN;
            end else if (q_new_bar) begin
              if (!smooth_on_r && cnt_r >= p_eff) begin
                mode_r    <= M_SEED;
                k_r       <= p_eff - 1'b1;
                issuing_r <= 1'b1;
                pend_r    <= 1'b0;
                first_r   <= 1'b1;
                su_r      <= '0;
                sd_r      <= '0;
                state_r   <= S_WALK;
              end else if (smooth_on_r) begin
                mode_r  <= M_SMOOTH;
                state_r <= S_MUL;
              end else begin
                mode_r  <= M_PUSH;
                state_r <= S_FIN;
              end
            end else if (smooth_on_r) begin
              mode_r  <= M_LIVE;
              state_r <= S_MUL;
            end else begin
              mode_r  <= M_HOLD;
              state_r <= S_FIN;
            end
          end
        end
        S_WALK: begin
          // Read oldest to newest, one close a cycle, summing the moves
          pend_r <= issuing_r;
          if (issuing_r) begin
            if (k_r == '0) begin
              issuing_r <= 1'b0;
            end else begin
              k_r <= k_r - 1'b1;
            end
          end
          if (pend_r) begin
            prev_r  <= rd_data_r;
            first_r <= 1'b0;
            if (!first_r) begin
              if (rd_data_r >= prev_r) begin
                su_r <= su_r + SW'(rd_data_r - prev_r);
              end else begin
                sd_r <= sd_r + SW'(prev_r - rd_data_r);
              end
            end
          end
          if (!issuing_r && !pend_r) begin
            // Closing bar against the newest held close
            if (bar_close_r >= prev_r) begin
              su_r <= su_r + SW'(bar_close_r - prev_r);
            end else begin
              sd_r <= sd_r + SW'(prev_r - bar_close_r);
            end
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mode_r == M_SEED) begin
            num_up_r <= NW'(su_r) << F;
            num_dn_r <= NW'(sd_r) << F;
          end else begin
            num_up_r <= NW'(prod_up) + (NW'(mu) << F);
            num_dn_r <= NW'(prod_dn) + (NW'(md) << F);
          end
          state_r <= S_DIVU;
        end
        S_DIVU: begin
          div_go_r <= 1'b1;
          if (div_done) begin
            t_up_r   <= AW'(div_q);
            div_go_r <= 1'b0;
            state_r  <= S_DIVD;
          end
        end
        S_DIVD: begin
          div_go_r <= 1'b1;
          if (div_done) begin
            t_dn_r   <= AW'(div_q);
            div_go_r <= 1'b0;
            state_r  <= S_RMUL;
          end
        end
        S_RMUL: begin
          prod_r   <= t_up_r * RSI_FULL;
          rden_r   <= sum_t;
          rn_ok_r  <= 1'b0;
          state_r  <= S_DIVR;
          div_go_r <= 1'b1;
        end
        S_DIVR: begin
          // On entry this state only forms the rounded numerator
          if (rden_r == '0) begin
            rsi_r    <= RSI_FULL;
            div_go_r <= 1'b0;
            state_r  <= S_FIN;
          end else if (!rn_ok_r) begin
            rn_ok_r  <= 1'b1;
            div_go_r <= 1'b0;
          end else begin
            div_go_r <= 1'b1;
            if (div_done) begin
              rsi_r    <= RSI_W'(div_q);
              div_go_r <= 1'b0;
              state_r  <= S_FIN;
            end
          end
        end
        S_FIN: begin
          case (mode_r)
            M_OPEN: begin
              bar_close_r <= price_r;
              bar_open_r  <= 1'b1;
            end
            M_HOLD: begin
              bar_close_r <= price_r;
            end
            M_LIVE: begin
              bar_close_r <= price_r;
              rsi_live_r  <= rsi_r;
            end
            M_SEED: begin
              avg_up_r    <= t_up_r;
              avg_dn_r    <= t_dn_r;
              rsi_final_r <= rsi_r;
              rsi_live_r  <= rsi_r;
              smooth_on_r <= 1'b1;
            end
            M_SMOOTH: begin
              avg_up_r    <= t_up_r;
              avg_dn_r    <= t_dn_r;
              rsi_final_r <= rsi_r;
            end
            default: begin
            end
          endcase
          if (mem_we) begin
            wp_r         <= (wp_r == AD'(MAX_PERIOD - 1)) ? '0 : wp_r + 1'b1;
            last_close_r <= bar_close_r;
            bar_close_r  <= price_r;
            if (cnt_r != PW'(MAX_PERIOD)) begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Hold until the result register is free
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            out_rsi_final   <= rsi_final_r;
            out_rsi_live    <= rsi_live_r;
            out_final_valid <= smooth_on_r;
            out_live_valid  <= smooth_on_r;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Rounded RSI numerator, registered from the product register
  always_ff @(posedge clk) begin
    rnum_r <= RNW'(prod_r) + RNW'(rden_r >> 1);
  end
endmodule

@@ design/wilder_rsi_indicator.sv @@
`timescale 1ns / 1ps
// Wilder RSI over price bars.
// in_ch carries one tick per transaction: price and new_bar. out_ch returns one
// result per tick: rsi_final, rsi_live (hundredths of a percent) and their
// valid flags, which rise once the first full window has seeded the averages.
// cfg_we/cfg_wdata write the period; write it only while no tick is in flight.
// A two-entry queue takes ticks while the back end works, so in_ch.ready stays
// high until the queue is full.
// Ticks that only move the bar skip the divider. A tick that smooths or gives
// a provisional RSI runs up to three divisions on one shared bit-serial
// divider of width DDW (DDW = PRICE_BITS + AVG_FRAC_BITS + 15, 63 at the
// defaults); the RSI division is skipped when both new averages are zero.
// The seeding close first walks the history. The back end takes the next
// tick from the queue only once it has finished the current one.
// Reset (synchronous, rst_n low) empties the queue, clears the bar, counts,
// smoothing flag, RSI values and held result, and sets the period to 14.
// If out_ch.ready is low the finished result waits in the output register;
// the back end finishes the next tick and then holds until that slot frees.
module wilder_rsi_indicator #(
  parameter int MAX_PERIOD    = wri_pkg::DEF_MAX_PERIOD,
  parameter int PRICE_BITS    = wri_pkg::DEF_PRICE_BITS,
  parameter int AVG_FRAC_BITS = wri_pkg::DEF_AVG_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  wri_in_if.sink                       in_ch,
  wri_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [wri_pkg::PERIOD_W-1:0] cfg_wdata
);
  import wri_pkg::*;

  logic                  q_valid, q_ready, q_new_bar;
  logic [PRICE_BITS-1:0] q_price;

  // Front: queue accepted ticks
  wri_front #(.PRICE_BITS(PRICE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_price   (in_ch.price),
    .in_new_bar (in_ch.new_bar),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_price    (q_price),
    .q_new_bar  (q_new_bar)
  );

  // Back: bar bookkeeping, averages and RSI
  wri_core #(
    .MAX_PERIOD    (MAX_PERIOD),
    .PRICE_BITS    (PRICE_BITS),
    .AVG_FRAC_BITS (AVG_FRAC_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_price         (q_price),
    .q_new_bar       (q_new_bar),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_rsi_final   (out_ch.rsi_final),
    .out_rsi_live    (out_ch.rsi_live),
    .out_final_valid (out_ch.final_valid),
    .out_live_valid  (out_ch.live_valid)
  );

`ifndef SYNTH
  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.rsi_final <= RSI_FULL) && (out_ch.rsi_live <= RSI_FULL))
    else $error("RSI out of range");

  a_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.final_valid == out_ch.live_valid))
    else $error("valid flags disagree");

  a_zero_before_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.final_valid) |->
      (out_ch.rsi_final == '0) && (out_ch.rsi_live == '0))
    else $error("RSI shown before seeding");

  a_seed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.final_valid) ##1 out_ch.valid
      |-> out_ch.final_valid)
    else $error("seeded state lost");
`endif
endmodule

@@ test/wilder_rsi_indicator_test.sv @@
`timescale 1ns / 1ps
module wilder_rsi_indicator_test;
  import wri_pkg::*;

  localparam int HIST_DEPTH = DEF_MAX_PERIOD;
  localparam int FRAC = DEF_AVG_FRAC_BITS;
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam logic [31:0] PMAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [RSI_W-1:0] fin;
    logic [RSI_W-1:0] live;
    logic             fin_ok;
    logic             live_ok;
  } rsi_result_t;

  typedef struct packed {
    logic [31:0] price;
    logic        nb;
    logic        typed;
    rsi_result_t res;
  } tick_row_t;

  localparam rsi_result_t R_NONE = '{fin: 14'd0, live: 14'd0, fin_ok: 1'b0, live_ok: 1'b0};
  localparam rsi_result_t R_FULL = '{fin: RSI_FULL, live: RSI_FULL, fin_ok: 1'b1, live_ok: 1'b1};
  localparam rsi_result_t R_DOWN = '{fin: RSI_FULL, live: 14'd0, fin_ok: 1'b1, live_ok: 1'b1};
  localparam int N_ROWS = 18;

  // Directed ticks, run with period 2
  localparam tick_row_t DIR_ROWS [N_ROWS] = '{
    '{price: 32'd100, nb: 1'b1, typed: 1'b1, res: R_NONE},   // no bar open yet
    '{price: 32'd0,   nb: 1'b0, typed: 1'b1, res: R_NONE},
    '{price: 32'd100, nb: 1'b0, typed: 1'b1, res: R_NONE},
    '{price: 32'd100, nb: 1'b1, typed: 1'b1, res: R_NONE},   // short window: push only
    '{price: 32'd100, nb: 1'b1, typed: 1'b1, res: R_NONE},
    '{price: 32'd0,   nb: 1'b1, typed: 1'b1, res: R_FULL},   // flat seed: both averages zero
    '{price: 32'd0,   nb: 1'b0, typed: 1'b1, res: R_DOWN},
    '{price: PMAX,    nb: 1'b0, typed: 1'b1, res: R_FULL},
    '{price: PMAX,    nb: 1'b1, typed: 1'b0, res: R_NONE},
    '{price: 32'd0,   nb: 1'b1, typed: 1'b0, res: R_NONE},
    '{price: PMAX,    nb: 1'b1, typed: 1'b0, res: R_NONE},
    '{price: 32'd0,   nb: 1'b0, typed: 1'b0, res: R_NONE},
    '{price: 32'd12345, nb: 1'b0, typed: 1'b0, res: R_NONE},
    '{price: 32'd12345, nb: 1'b1, typed: 1'b0, res: R_NONE},
    '{price: 32'h8000_0000, nb: 1'b1, typed: 1'b0, res: R_NONE},
    '{price: 32'h7FFF_FFFF, nb: 1'b0, typed: 1'b0, res: R_NONE},
    '{price: 32'h5555_5555, nb: 1'b1, typed: 1'b0, res: R_NONE},
    '{price: 32'hAAAA_AAAA, nb: 1'b0, typed: 1'b0, res: R_NONE}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;

  wri_in_if #(.PRICE_BITS(DEF_PRICE_BITS)) in_ch ();
  wri_out_if out_ch ();

  wilder_rsi_indicator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow state of the indicator
  logic [PERIOD_W-1:0] m_bars;
  logic [31:0] m_hist [HIST_DEPTH];
  int          m_closed;
  logic [31:0] m_bar_close;
  logic        m_bar_open;
  logic [63:0] m_up;
  logic [63:0] m_down;
  logic        m_smoothing;
  logic [RSI_W-1:0] m_rsi_fin;
  logic [RSI_W-1:0] m_rsi_live;

  rsi_result_t pending_rsi [$];
  int mismatches;
  int snd_idle;
  int rcv_idle;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int eff_period();
    if (m_bars < MIN_PERIOD) return MIN_PERIOD;
    if (m_bars > HIST_DEPTH) return HIST_DEPTH;
    return int'(m_bars);
  endfunction

  function automatic logic [RSI_W-1:0] strength(logic [63:0] up, logic [63:0] down);
    logic [63:0] total;
    total = up + down;
    if (total == 0) return RSI_FULL;
    return RSI_W'((up * 64'd10000 + total / 2) / total);
  endfunction

  function automatic logic [63:0] wilder_avg(logic [63:0] avg, logic [63:0] move, int p);
    return (avg * 64'(p - 1) + (move << FRAC)) / 64'(p);
  endfunction

  // Advance the shadow state by one tick and return the result it gives
  function automatic rsi_result_t rsi_on_tick(logic [31:0] price, logic nb);
    int p;
    logic [63:0] su, sd, a, b, prev, mu, md;
    rsi_result_t r;
    p = eff_period();
    su = 0;
    sd = 0;
    if (!m_bar_open) begin
      m_bar_close = price;
      m_bar_open = 1'b1;
    end else if (nb) begin
      if (!m_smoothing && m_closed >= p) begin
        for (int k = p - 1; k >= 1; k--) begin
          a = m_hist[k];
          b = m_hist[k-1];
          if (b >= a) su += b - a; else sd += a - b;
        end
        if (m_bar_close >= m_hist[0]) su += m_bar_close - m_hist[0];
        else sd += m_hist[0] - m_bar_close;
        m_up = (su << FRAC) / 64'(p);
        m_down = (sd << FRAC) / 64'(p);
        m_rsi_fin = strength(m_up, m_down);
        m_rsi_live = m_rsi_fin;
        m_smoothing = 1'b1;
      end else if (m_smoothing) begin
        prev = m_hist[0];
        mu = (m_bar_close >= prev) ? m_bar_close - prev : 0;
        md = (m_bar_close < prev) ? prev - m_bar_close : 0;
        m_up = wilder_avg(m_up, mu, p);
        m_down = wilder_avg(m_down, md, p);
        m_rsi_fin = strength(m_up, m_down);
      end
      for (int k = HIST_DEPTH - 1; k >= 1; k--) m_hist[k] = m_hist[k-1];
      m_hist[0] = m_bar_close;
      if (m_closed < HIST_DEPTH) m_closed++;
      m_bar_close = price;
    end else begin
      m_bar_close = price;
      if (m_smoothing && m_closed >= 1) begin
        prev = m_hist[0];
        mu = (m_bar_close >= prev) ? m_bar_close - prev : 0;
        md = (m_bar_close < prev) ? prev - m_bar_close : 0;
        m_rsi_live = strength(wilder_avg(m_up, mu, p), wilder_avg(m_down, md, p));
      end
    end
    r.fin = m_smoothing ? m_rsi_fin : '0;
    r.live = m_smoothing ? m_rsi_live : '0;
    r.fin_ok = m_smoothing;
    r.live_ok = m_smoothing;
    return r;
  endfunction

  // Send one tick; queue the typed or the predicted result once accepted
  task automatic send_tick(logic [31:0] price, logic nb, logic typed, rsi_result_t given);
    rsi_result_t r;
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.price <= price;
    in_ch.new_bar <= nb;
    do @(posedge clk); while (!in_ch.ready);
    r = rsi_on_tick(price, nb);
    pending_rsi.push_back(typed ? given : r);
  endtask

  // Hold until every result is back, then let the back end settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_rsi.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    m_bars = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly bars of a few ticks walking the price; some jumps and noise
  task automatic run_bars(int count);
    logic [31:0] price;
    logic nb;
    int left;
    price = $urandom;
    left = 0;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0: price = $urandom;
        1: price = 32'd0;
        2: price = PMAX;
        3, 4: ;
        default: begin
          if ($urandom_range(1)) price = price + $urandom_range(1 << $urandom_range(20));
          else price = price - $urandom_range(1 << $urandom_range(20));
        end
      endcase
      if ($urandom_range(9) == 0) nb = 1'($urandom_range(1));
      else begin
        nb = (left == 0);
        left = (left == 0) ? $urandom_range(3) : left - 1;
      end
      send_tick(price, nb, 1'b0, R_NONE);
    end
  endtask

  // Check each returned result and pace the receiver
  always @(posedge clk) begin
    rsi_result_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{fin: out_ch.rsi_final, live: out_ch.rsi_live,
              fin_ok: out_ch.final_valid, live_ok: out_ch.live_valid};
      if (pending_rsi.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = pending_rsi.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"rsi mismatch: expected fin=%0d live=%0d fv=%0b lv=%0b, ",
                      "got fin=%0d live=%0d fv=%0b lv=%0b"},
                     want.fin, want.live, want.fin_ok, want.live_ok,
                     got.fin, got.live, got.fin_ok, got.live_ok);
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL wilder_rsi_indicator");
      $finish;
    end
  end

  initial begin
    logic [PERIOD_W-1:0] phase_period [7];
    mismatches = 0;
    stall_cycles = 0;
    snd_idle = 27;
    rcv_idle = 84;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.price = '0;
    in_ch.new_bar = 1'b0;
    out_ch.ready = 1'b0;

    // Reset state of the shadow model
    m_bars = PERIOD_RESET;
    foreach (m_hist[k]) m_hist[k] = '0;
    m_closed = 0;
    m_bar_close = '0;
    m_bar_open = 1'b0;
    m_up = '0;
    m_down = '0;
    m_smoothing = 1'b0;
    m_rsi_fin = '0;
    m_rsi_live = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks at the shortest period
    write_period(7'd2);
    for (int i = 0; i < N_ROWS; i++)
      send_tick(DIR_ROWS[i].price, DIR_ROWS[i].nb, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    drain();

    // Random phases over a spread of periods and idling patterns
    phase_period = '{7'd0, 7'd64, 7'd1, 7'd127, PERIOD_RESET, 7'd65, 7'($urandom_range(3, 40))};
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 3) begin
        snd_idle = 27;
        rcv_idle = 84;
      end else if (ph < 5) begin
        snd_idle = 84;
        rcv_idle = 27;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      write_period(phase_period[ph]);
      run_bars(50);
      drain();
      run_bars(55);
      drain();
    end

    if (mismatches == 0) $display("PASS wilder_rsi_indicator");
    else $display("FAIL wilder_rsi_indicator");
    $finish;
  end
endmodule
